>>> rtl/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// Types and codes shared by the deque-with-search front end, back end and top.
// ----------------------------------------------------------------------------
package dws_pkg;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_FIND       = 3'd4;
	localparam logic [2:0] CMD_READ       = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		OPC_PUSH_FRONT,
		OPC_PUSH_BACK,
		OPC_POP_FRONT,
		OPC_POP_BACK,
		OPC_FIND,
		OPC_READ,
		OPC_BAD
	} opc_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SCAN
	} bk_state_t;

	typedef struct packed {
		logic        [2:0]  cmd;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] data;
		logic        [7:0]  found_position;
		logic        [8:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		opc_t               code;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} op_t;

endpackage

>>> rtl/dws_front.sv
// ----------------------------------------------------------------------------
// dws_front
// Accepts requests, decodes the command and holds decoded operations in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dws_front
	import dws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic q_valid,
	output op_t  q_op,
	input  logic q_take
);

	op_t        slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	op_t        dec;

	always_comb begin
		dec.value    = req.value;
		dec.position = req.position;
		case (req.cmd)
			CMD_PUSH_FRONT: dec.code = OPC_PUSH_FRONT;
			CMD_PUSH_BACK:  dec.code = OPC_PUSH_BACK;
			CMD_POP_FRONT:  dec.code = OPC_POP_FRONT;
			CMD_POP_BACK:   dec.code = OPC_POP_BACK;
			CMD_FIND:       dec.code = OPC_FIND;
			CMD_READ:       dec.code = OPC_READ;
			default:        dec.code = OPC_BAD;
		endcase
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign q_valid   = (fill_q != 2'd0);
	assign q_op      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_take)
				rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= dec;
	end

endmodule

>>> rtl/dws_back.sv
// ----------------------------------------------------------------------------
// dws_back
// Executes queued operations on the ring-buffer store and registers results.
// ----------------------------------------------------------------------------
module dws_back
	import dws_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  op_t  q_op,
	output logic q_take,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int XW = (CW > 8) ? CW : 8;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;

	bk_state_t state_q;
	bk_state_t nxt_state;
	logic [AW-1:0] head_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_d;
	logic          cmp_valid_s1;
	logic          cmp_valid_d;
	logic [CW-1:0] cmp_idx_s1;
	logic [CW-1:0] cmp_idx_d;
	op_t           cur_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic          out_free;
	logic          full;
	logic          empty;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          fin;
	rsp_t          fin_res;
	logic [AW-1:0] head_dec;

	function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH))
			sum = sum - SW'(DEPTH);
		return AW'(sum);
	endfunction

	assign out_free = !out_valid_q || !rsp_stall;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : AW'(head_q - AW'(1));

	always_comb begin
		nxt_state = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_take && rd_en)
					nxt_state = BK_READ;
				else if (q_take && q_op.code == OPC_FIND)
					nxt_state = BK_SCAN;
			end
			BK_READ: begin
				if (fin)
					nxt_state = BK_IDLE;
			end
			BK_SCAN: begin
				if (fin)
					nxt_state = BK_IDLE;
			end
			default: nxt_state = BK_IDLE;
		endcase
	end

	always_comb begin
		q_take      = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		fin         = 1'b0;
		head_d      = head_q;
		count_d     = count_q;
		idx_d       = idx_q;
		cmp_valid_d = cmp_valid_s1;
		cmp_idx_d   = cmp_idx_s1;
		fin_res.status         = ST_OK;
		fin_res.data           = '0;
		fin_res.found_position = '0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					q_take = 1'b1;
					case (q_op.code)
						OPC_PUSH_FRONT: begin
							fin = 1'b1;
							if (full) begin
								fin_res.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = head_dec;
								head_d  = head_dec;
								count_d = count_q + CW'(1);
							end
						end
						OPC_PUSH_BACK: begin
							fin = 1'b1;
							if (full) begin
								fin_res.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = ring(head_q, count_q);
								count_d = count_q + CW'(1);
							end
						end
						OPC_POP_FRONT: begin
							if (empty) begin
								fin            = 1'b1;
								fin_res.status = ST_MISS;
							end else begin
								rd_en   = 1'b1;
								rd_addr = head_q;
							end
						end
						OPC_POP_BACK: begin
							if (empty) begin
								fin            = 1'b1;
								fin_res.status = ST_MISS;
							end else begin
								rd_en   = 1'b1;
								rd_addr = ring(head_q, count_q - CW'(1));
							end
						end
						OPC_READ: begin
							if (XW'(q_op.position) >= XW'(count_q)) begin
								fin            = 1'b1;
								fin_res.status = ST_MISS;
							end else begin
								rd_en   = 1'b1;
								rd_addr = ring(head_q, CW'(q_op.position));
							end
						end
						OPC_FIND: begin
							idx_d       = '0;
							cmp_valid_d = 1'b0;
						end
						default: begin
							fin            = 1'b1;
							fin_res.status = ST_MISS;
						end
					endcase
				end
			end
			BK_READ: begin
				if (out_free) begin
					fin          = 1'b1;
					fin_res.data = rdata_q;
					case (cur_q.code)
						OPC_POP_FRONT: begin
							head_d  = ring(head_q, CW'(1));
							count_d = count_q - CW'(1);
						end
						OPC_POP_BACK: count_d = count_q - CW'(1);
						default: ;
					endcase
				end
			end
			BK_SCAN: begin
				if (cmp_valid_s1 && rdata_q == cur_q.value) begin
					if (out_free) begin
						fin                    = 1'b1;
						fin_res.found_position = 8'(cmp_idx_s1);
						cmp_valid_d            = 1'b0;
					end
				end else if (idx_q < count_q) begin
					rd_en       = 1'b1;
					rd_addr     = ring(head_q, idx_q);
					idx_d       = idx_q + CW'(1);
					cmp_valid_d = 1'b1;
					cmp_idx_d   = idx_q;
				end else begin
					cmp_valid_d = 1'b0;
					if (!cmp_valid_s1 && out_free) begin
						fin            = 1'b1;
						fin_res.status = ST_MISS;
					end
				end
			end
			default: ;
		endcase
		fin_res.occupancy = 9'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= nxt_state;
			head_q       <= head_d;
			count_q      <= count_d;
			idx_q        <= idx_d;
			cmp_valid_s1 <= cmp_valid_d;
			if (fin)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= cmp_idx_d;
		if (q_take)
			cur_q <= q_op;
		if (fin)
			out_q <= fin_res;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= q_op.value;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> rtl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of signed 32-bit values with search by value.
// ----------------------------------------------------------------------------
// Requests enter on req (cmd, value, position) under req_valid / req_stall;
// a transfer happens at a clock edge with valid high and stall low. Each
// request gives exactly one response on rsp (status, data, found_position,
// occupancy) under rsp_valid / rsp_stall, in request order.
// A two-entry command queue sits behind the request port, so new requests
// are taken while the back end works or a response waits on rsp_stall.
// Push and rejected commands finish in the cycle the back end takes them;
// pop and read add one registered read of the entry store. Find reads one
// entry per cycle from the front and compares it in the following cycle:
// the scan ends at the first match, or with a miss once all count entries
// are compared (with no read on an empty deque).
// A response passes the command queue and the response register; pop and
// read also pass the registered read of the entry store.
// While rsp_stall is high the finished response holds and the back end
// waits; the queue fills and then raises req_stall.
// Reset empties the deque (head and count cleared) and drops queued and
// pending responses. The entry store is not cleared; entries are only read
// after they are written.
// ----------------------------------------------------------------------------
module deque_with_search
	import dws_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic q_valid;
	op_t  q_op;
	logic q_take;

	dws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_take    (q_take)
	);

	dws_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.q_take    (q_take),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
